FILE: src/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the frame deframer, its parser and checker.
// ----------------------------------------------------------------------------
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT16,
    PH_EXT64,
    PH_MASK,
    PH_PAYLOAD
  } wsd_phase_t;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  localparam logic [2:0] MSG_TEXT   = 3'd0;
  localparam logic [2:0] MSG_BINARY = 3'd1;
  localparam logic [2:0] MSG_CLOSE  = 3'd2;
  localparam logic [2:0] MSG_PING   = 3'd3;
  localparam logic [2:0] MSG_PONG   = 3'd4;

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd8192;

  localparam int TDATA_W = 32;
  localparam int TUSER_W = 4;

  typedef struct packed {
    logic        has_data;
    logic [7:0]  data_byte;
    logic [2:0]  message_type;
    logic        final_fragment;
    logic [15:0] kept_length;
    logic        truncated;
    logic        last;
  } wsd_result_t;

  function automatic logic [2:0] msg_type(input logic [3:0] opcode);
    logic [2:0] t;
    case (opcode)
      OP_TEXT:   t = MSG_TEXT;
      OP_BINARY: t = MSG_BINARY;
      OP_CLOSE:  t = MSG_CLOSE;
      OP_PING:   t = MSG_PING;
      OP_PONG:   t = MSG_PONG;
      default:   t = MSG_TEXT;
    endcase
    return t;
  endfunction

endpackage

FILE: src/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header parser and payload unmasker; one byte per step.
// ----------------------------------------------------------------------------
module wsd_parser
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] max_payload,
  output logic        res_valid,
  output wsd_result_t res
);

  wsd_phase_t  phase, phase_next;
  logic [3:0]  field_byte_count, field_byte_count_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic        frame_fin, frame_fin_next;
  logic        frame_masked, frame_masked_next;
  logic [63:0] announced_length, announced_length_next;
  logic [31:0] mask_key, mask_key_next;
  logic [63:0] payload_position, payload_position_next;

  logic        len_fin;
  logic        hdr_fin;
  logic [15:0] kept_next;
  logic        trunc_next;
  logic        pos_in_range;
  logic [7:0]  key_byte;
  logic [63:0] pos_inc;

  assign kept_next  = (announced_length_next < {48'd0, max_payload}) ?
                      announced_length_next[15:0] : max_payload;
  assign trunc_next = announced_length_next > {48'd0, max_payload};
  assign pos_inc    = payload_position + 64'd1;
  assign pos_in_range = payload_position < {48'd0, kept_next};

  always_comb begin
    case (payload_position[1:0])
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  // datapath registers and completion flags
  always_comb begin
    field_byte_count_next = field_byte_count;
    frame_opcode_next     = frame_opcode;
    frame_fin_next        = frame_fin;
    frame_masked_next     = frame_masked;
    announced_length_next = announced_length;
    mask_key_next         = mask_key;
    payload_position_next = payload_position;
    len_fin               = 1'b0;
    hdr_fin               = 1'b0;
    case (phase)
      PH_HDR1: begin
        frame_masked_next     = rx_byte[7];
        field_byte_count_next = 4'd0;
        if (rx_byte[6:0] != LEN_EXT16 && rx_byte[6:0] != LEN_EXT64) begin
          announced_length_next = {57'd0, rx_byte[6:0]};
          len_fin               = 1'b1;
        end
      end
      PH_EXT16, PH_EXT64: begin
        announced_length_next = {announced_length[55:0], rx_byte};
        field_byte_count_next = field_byte_count + 4'd1;
        len_fin = field_byte_count_next ==
                  ((phase == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES);
      end
      PH_MASK: begin
        mask_key_next         = {mask_key[23:0], rx_byte};
        field_byte_count_next = field_byte_count + 4'd1;
        hdr_fin               = field_byte_count_next == KEY_BYTES;
      end
      PH_PAYLOAD: begin
        payload_position_next = pos_inc;
      end
      default: begin
        frame_fin_next        = rx_byte[7];
        frame_opcode_next     = rx_byte[3:0];
        frame_masked_next     = 1'b0;
        announced_length_next = 64'd0;
        mask_key_next         = 32'd0;
        payload_position_next = 64'd0;
        field_byte_count_next = 4'd0;
      end
    endcase
    if (len_fin) begin
      if (frame_masked_next) begin
        field_byte_count_next = 4'd0;
      end else begin
        hdr_fin = 1'b1;
      end
    end
    if (hdr_fin) begin
      payload_position_next = 64'd0;
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HDR0: phase_next = PH_HDR1;
      PH_HDR1: begin
        if (rx_byte[6:0] == LEN_EXT16) begin
          phase_next = PH_EXT16;
        end else if (rx_byte[6:0] == LEN_EXT64) begin
          phase_next = PH_EXT64;
        end
      end
      PH_PAYLOAD: begin
        if (pos_inc >= announced_length) begin
          phase_next = PH_HDR0;
        end
      end
      default: phase_next = phase;
    endcase
    if (len_fin && frame_masked_next) begin
      phase_next = PH_MASK;
    end else if (hdr_fin) begin
      if (kept_next == 16'd0 && announced_length_next == 64'd0) begin
        phase_next = PH_HDR0;
      end else begin
        phase_next = PH_PAYLOAD;
      end
    end
  end

  // result
  always_comb begin
    res.message_type   = msg_type(frame_opcode_next);
    res.final_fragment = frame_fin_next;
    res.kept_length    = kept_next;
    res.truncated      = trunc_next;
    res.has_data       = 1'b0;
    res.data_byte      = 8'd0;
    res.last           = 1'b0;
    res_valid          = 1'b0;
    if (hdr_fin) begin
      res.last  = 1'b1;
      res_valid = kept_next == 16'd0;
    end else if (phase == PH_PAYLOAD && pos_in_range) begin
      res_valid     = 1'b1;
      res.has_data  = 1'b1;
      res.data_byte = frame_masked ? (rx_byte ^ key_byte) : rx_byte;
      res.last      = pos_inc == {48'd0, kept_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HDR0;
      field_byte_count <= 4'd0;
      frame_opcode     <= 4'd0;
      frame_fin        <= 1'b0;
      frame_masked     <= 1'b0;
      announced_length <= 64'd0;
      mask_key         <= 32'd0;
      payload_position <= 64'd0;
    end else if (step) begin
      phase            <= phase_next;
      field_byte_count <= field_byte_count_next;
      frame_opcode     <= frame_opcode_next;
      frame_fin        <= frame_fin_next;
      frame_masked     <= frame_masked_next;
      announced_length <= announced_length_next;
      mask_key         <= mask_key_next;
      payload_position <= payload_position_next;
    end
  end

endmodule

FILE: src/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side frame deframer: parses headers, unmasks and caps payload.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries the raw received stream, one byte per transaction in
//   s_tdata. Header, extended length and mask key bytes are consumed;
//   each kept payload byte leaves as one m_* transaction, unmasked, with
//   m_tlast on the final kept byte. A frame that keeps no payload gives
//   a single transaction with has_data low and m_tlast high.
//   cfg_* writes max_payload (reset 8192); write it only while idle.
//   Each result is registered in the output register, or in the skid register on a stall.
//   Throughput: one byte per cycle while s_tready is high, set by the single parser stage.
//   An output register plus a skid register keep s_tready registered; a
//   stalled receiver fills the skid register, and s_tready then drops
//   until it drains. Reset clears the parser to await a frame header,
//   empties both registers and restores max_payload.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] rx_byte
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [7:0] data_byte, [8] final_fragment,
                                        // [24:9] kept_length, [25] truncated
  output logic [TUSER_W-1:0] m_tuser,   // [0] has_data, [3:1] message_type
  output logic               m_tlast,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  logic [15:0] max_payload;
  logic        in_fire;
  logic        res_valid;
  wsd_result_t res;
  logic        out_valid;
  wsd_result_t out_r;
  logic        skid_valid;
  wsd_result_t skid_r;
  logic        out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_payload <= cfg_data;
    end
  end

  wsd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (in_fire),
    .rx_byte     (s_tdata),
    .max_payload (max_payload),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire && res_valid;
      end
    end else if (in_fire && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid ? skid_r : res;
    end
    if (!out_free && in_fire) begin
      skid_r <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_r.truncated, out_r.kept_length,
                     out_r.final_fragment, out_r.data_byte};
  assign m_tuser  = {out_r.message_type, out_r.has_data};
  assign m_tlast  = out_r.last;

endmodule

FILE: src/wsd_checker.sv
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks on the frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module wsd_checker
  import wsd_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic [TUSER_W-1:0] m_tuser,
  input logic               m_tlast
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result presented after reset");

  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata[7:0] == 8'd0)
    else $error("result without data is not a clean frame end");

  a_type_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[3:1] <= MSG_PONG)
    else $error("message type out of range");

  a_no_input_when_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && s_tvalid && s_tready |=> m_tvalid && !s_tready
      || m_tvalid)
    else $error("skid handling lost a result");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
